### hw/rtl/sorted_key_value_table_top_assert.svh
// Assertion macros for the sorted key/value table.
// Included by the top level; needs nothing else.
`ifndef SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SKVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
// Used by skvt_cell and sorted_key_value_table_top; no dependencies.
`default_nettype none

package skvt_pkg;

    // Fixed field widths of the stream payloads
    localparam int FUNC_W     = 3;
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ENTRIES_W  = 5;
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 72;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 3'd0,
        FN_GET    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_FIRST  = 3'd3,
        FN_NEXT   = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Broadcast from controller to every cell
    typedef struct packed {
        logic look;      // compare lookup key, latch flags
        logic is_get;    // select on key match rather than index
        logic sgn;       // signed key order
        logic ins;       // insert new pair at sorted place
        logic rem;       // close the gap of the matching entry
        logic upd;       // overwrite value of the matching entry
    } t_cell_ctl;

    // Per-cell compare results, passed down the chain and to the controller
    typedef struct packed {
        logic match;     // this cell holds the lookup key
        logic less;      // this cell and every cell before it are below the key
        logic past;      // the matching cell is this one or an earlier one
    } t_cell_flags;

endpackage

`default_nettype wire

### hw/rtl/skvt_cell.sv
// One slot of the sorted table: holds a key/value pair, compares it against
// the broadcast key and shifts to/from its neighbors. Depends on skvt_pkg.
`default_nettype none

module skvt_cell #(
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  wire                      i_clk,
    input  skvt_pkg::t_cell_ctl      i_ctl,
    input  wire  [KEY_WIDTH-1:0]     i_look_key,
    input  wire  [CNT_W-1:0]         i_count,
    input  wire  [IDX_W-1:0]         i_idx,
    input  wire  [KEY_WIDTH-1:0]     i_new_key,
    input  wire  [DATA_WIDTH-1:0]    i_new_value,
    input  wire                      i_prev_less,
    input  wire                      i_prev_past,
    input  wire  [KEY_WIDTH-1:0]     i_prev_key,
    input  wire  [DATA_WIDTH-1:0]    i_prev_value,
    input  wire  [KEY_WIDTH-1:0]     i_next_key,
    input  wire  [DATA_WIDTH-1:0]    i_next_value,
    output skvt_pkg::t_cell_flags    o_flags,
    output logic [KEY_WIDTH-1:0]     o_key,
    output logic [DATA_WIDTH-1:0]    o_value,
    output logic [KEY_WIDTH-1:0]     o_rd_key,
    output logic [DATA_WIDTH-1:0]    o_rd_value
);

    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
    localparam logic [CNT_W-1:0]     MY_CNT    = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0]     MY_IDX    = IDX_W'(INDEX);

    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_match;
    logic                  r_less;
    logic                  r_sel;

    logic                  w_occ;
    logic                  w_match;
    logic                  w_less;
    logic [KEY_WIDTH-1:0]  w_flip;
    logic                  w_lt_run;
    logic                  w_past;

    // Compare against the lookup key; signed order flips the sign bit
    assign w_occ   = MY_CNT < i_count;
    assign w_flip  = i_ctl.sgn ? SIGN_MASK : '0;
    assign w_match = w_occ && (r_key == i_look_key);
    assign w_less  = w_occ && ((r_key ^ w_flip) < (i_look_key ^ w_flip));

    // Flags latched on the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.look) begin
            r_match <= w_match;
            r_less  <= w_less;
            r_sel   <= i_ctl.is_get ? w_match : (i_idx == MY_IDX);
        end
    end

    // Run of smaller keys from the head, and match seen from the head
    assign w_lt_run = r_less && i_prev_less;
    assign w_past   = r_match || i_prev_past;

    // Entry storage: insert shifts up, remove shifts down, update overwrites the value
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (!w_lt_run) begin
                if (i_prev_less) begin
                    r_key   <= i_new_key;
                    r_value <= i_new_value;
                end else begin
                    r_key   <= i_prev_key;
                    r_value <= i_prev_value;
                end
            end
        end else if (i_ctl.rem) begin
            if (w_past) begin
                r_key   <= i_next_key;
                r_value <= i_next_value;
            end
        end else if (i_ctl.upd && r_match) begin
            r_value <= i_new_value;
        end
    end

    assign o_flags.match = r_match;
    assign o_flags.less  = w_lt_run;
    assign o_flags.past  = w_past;
    assign o_key         = r_key;
    assign o_value       = r_value;
    assign o_rd_key      = r_sel ? r_key : '0;
    assign o_rd_value    = r_sel ? r_value : '0;

endmodule

`default_nettype wire

### hw/rtl/sorted_key_value_table_top.sv
// Top level of the sorted key/value table: controller, cell chain, output register.
// Depends on skvt_pkg, skvt_cell and sorted_key_value_table_top_assert.svh.
//
//  Channel  Dir  Handshake                        Payload (low bit up)
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready  func[3] key[32] value[32] pad[5]
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready  status[2] found key_out data_out entries[5]
//  cfg      in   i_cfg_we                         signed_keys[1]
//
// Each operation runs as a compare step, in which every cell compares its key
// with the request in parallel on acceptance, then a step in which the cells shift or update.
// Reset is synchronous, active low; it empties the table and ends any walk.
// The result sits in an output register; a stalled master holds the engine in
// its execute state while an earlier result is still unaccepted, so nothing is dropped.
`default_nettype none

module sorted_key_value_table_top #(
    parameter int CAPACITY   = 16,
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // func[2:0], key[34:3], value[66:35], zero[71:67]
    input  wire  [skvt_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // status[1:0], found[2], key_out[34:3], data_out[66:35], entries[71:67]
    output logic [skvt_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_wdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control state
    skvt_pkg::t_state        r_state;
    skvt_pkg::t_state        n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [IDX_W-1:0]        r_iter_pos;
    logic [IDX_W-1:0]        n_iter_pos;
    logic                    r_iter_valid;
    logic                    n_iter_valid;
    logic                    r_signed;
    logic                    r_out_valid;

    // Held request and result payload
    skvt_pkg::t_func         r_func;
    logic [KEY_WIDTH-1:0]    r_key;
    logic [DATA_WIDTH-1:0]   r_value;
    logic [skvt_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Request decode
    logic                    w_accept;
    logic                    w_commit;
    logic                    w_exec;
    skvt_pkg::t_func         w_in_func;
    logic [KEY_WIDTH-1:0]    w_in_key;
    logic [DATA_WIDTH-1:0]   w_in_value;
    logic [IDX_W-1:0]        w_idx;
    logic [CNT_W-1:0]        w_iter_next;

    // Execute decisions
    logic                    w_any_match;
    logic [skvt_pkg::STATUS_W-1:0] w_status;
    logic                    w_found;
    logic                    w_ins;
    logic                    w_rem;
    logic                    w_upd;
    skvt_pkg::t_cell_ctl     w_ctl;

    // Cell chain wiring
    skvt_pkg::t_cell_flags   w_flags   [CAPACITY];
    logic [CAPACITY-1:0]     w_match;
    logic [KEY_WIDTH-1:0]    w_cell_key   [CAPACITY];
    logic [DATA_WIDTH-1:0]   w_cell_value [CAPACITY];
    logic [KEY_WIDTH-1:0]    w_rd_key_c   [CAPACITY];
    logic [DATA_WIDTH-1:0]   w_rd_value_c [CAPACITY];
    logic [KEY_WIDTH-1:0]    w_rd_key;
    logic [DATA_WIDTH-1:0]   w_rd_value;

    // Input unpacking
    assign w_in_func  = skvt_pkg::t_func'(i_s_axis_tdata[2:0]);
    assign w_in_key   = KEY_WIDTH'(i_s_axis_tdata[34:3]);
    assign w_in_value = DATA_WIDTH'(i_s_axis_tdata[66:35]);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exec     = (r_state == skvt_pkg::S_EXEC);
    assign w_iter_next = CNT_W'(r_iter_pos) + CNT_W'(1);
    assign w_idx      = (w_in_func == skvt_pkg::FN_FIRST) ? '0 : r_iter_pos + IDX_W'(1);

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skvt_pkg::S_IDLE: begin
                if (w_accept) n_state = skvt_pkg::S_EXEC;
            end
            skvt_pkg::S_EXEC: begin
                if (w_commit) n_state = skvt_pkg::S_IDLE;
            end
            default: n_state = skvt_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_commit        = 1'b0;
        unique case (r_state)
            skvt_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            skvt_pkg::S_EXEC: w_commit = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // Operation decisions from the latched cell flags
    assign w_any_match = |w_match;

    always_comb begin
        n_count      = r_count;
        n_iter_pos   = r_iter_pos;
        n_iter_valid = r_iter_valid;
        w_status     = skvt_pkg::ST_OK;
        w_found      = 1'b0;
        w_ins        = 1'b0;
        w_rem        = 1'b0;
        w_upd        = 1'b0;
        unique case (r_func)
            skvt_pkg::FN_PUT: begin
                n_iter_valid = 1'b0;
                if (w_any_match) begin
                    w_upd = 1'b1;
                end else if (r_count >= CAP_CNT) begin
                    w_status = skvt_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            skvt_pkg::FN_GET: begin
                if (w_any_match) w_found = 1'b1;
                else             w_status = skvt_pkg::ST_MISSING;
            end
            skvt_pkg::FN_REMOVE: begin
                n_iter_valid = 1'b0;
                if (w_any_match) begin
                    w_rem   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = skvt_pkg::ST_MISSING;
                end
            end
            skvt_pkg::FN_FIRST: begin
                if (r_count == '0) begin
                    n_iter_valid = 1'b0;
                    w_status     = skvt_pkg::ST_MISSING;
                end else begin
                    n_iter_pos   = '0;
                    n_iter_valid = 1'b1;
                    w_found      = 1'b1;
                end
            end
            skvt_pkg::FN_NEXT: begin
                if (!r_iter_valid || (w_iter_next >= r_count)) begin
                    n_iter_valid = 1'b0;
                    w_status     = skvt_pkg::ST_MISSING;
                end else begin
                    n_iter_pos = r_iter_pos + IDX_W'(1);
                    w_found    = 1'b1;
                end
            end
            skvt_pkg::FN_CLEAR: begin
                n_count      = '0;
                n_iter_pos   = '0;
                n_iter_valid = 1'b0;
            end
            default: w_status = skvt_pkg::ST_MISSING;
        endcase
    end

    // Broadcast to cells
    assign w_ctl.look   = w_accept;
    assign w_ctl.is_get = (w_in_func == skvt_pkg::FN_GET);
    assign w_ctl.sgn    = r_signed;
    assign w_ctl.ins    = w_commit && w_ins;
    assign w_ctl.rem    = w_commit && w_rem;
    assign w_ctl.upd    = w_commit && w_upd;

    // Chain of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                  w_p_less;
        logic                  w_p_past;
        logic [KEY_WIDTH-1:0]  w_p_key;
        logic [DATA_WIDTH-1:0] w_p_value;
        logic [KEY_WIDTH-1:0]  w_n_key;
        logic [DATA_WIDTH-1:0] w_n_value;

        if (g == 0) begin : g_head
            assign w_p_less  = 1'b1;
            assign w_p_past  = 1'b0;
            assign w_p_key   = '0;
            assign w_p_value = '0;
        end else begin : g_mid
            assign w_p_less  = w_flags[g-1].less;
            assign w_p_past  = w_flags[g-1].past;
            assign w_p_key   = w_cell_key[g-1];
            assign w_p_value = w_cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_n_key   = '0;
            assign w_n_value = '0;
        end else begin : g_body
            assign w_n_key   = w_cell_key[g+1];
            assign w_n_value = w_cell_value[g+1];
        end

        skvt_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_look_key   (w_in_key),
            .i_count      (r_count),
            .i_idx        (w_idx),
            .i_new_key    (r_key),
            .i_new_value  (r_value),
            .i_prev_less  (w_p_less),
            .i_prev_past  (w_p_past),
            .i_prev_key   (w_p_key),
            .i_prev_value (w_p_value),
            .i_next_key   (w_n_key),
            .i_next_value (w_n_value),
            .o_flags      (w_flags[g]),
            .o_key        (w_cell_key[g]),
            .o_value      (w_cell_value[g]),
            .o_rd_key     (w_rd_key_c[g]),
            .o_rd_value   (w_rd_value_c[g])
        );

        assign w_match[g] = w_flags[g].match;
    end

    // Selected entry: at most one cell drives a nonzero read
    always_comb begin
        w_rd_key   = '0;
        w_rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_key   = w_rd_key | w_rd_key_c[i];
            w_rd_value = w_rd_value | w_rd_value_c[i];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= skvt_pkg::S_IDLE;
            r_count      <= '0;
            r_iter_pos   <= '0;
            r_iter_valid <= 1'b0;
            r_signed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_signed <= i_cfg_wdata;
            if (w_commit) begin
                r_count      <= n_count;
                r_iter_pos   <= n_iter_pos;
                r_iter_valid <= n_iter_valid;
                r_out_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= w_in_func;
            r_key   <= w_in_key;
            r_value <= w_in_value;
        end
        if (w_commit) begin
            r_out_data[1:0]   <= w_status;
            r_out_data[2]     <= w_found;
            r_out_data[34:3]  <= w_found ? skvt_pkg::FIELD_W'(w_rd_key) : '0;
            r_out_data[66:35] <= w_found ? skvt_pkg::FIELD_W'(w_rd_value) : '0;
            r_out_data[71:67] <= skvt_pkg::ENTRIES_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    `include "sorted_key_value_table_top_assert.svh"

    `SKVT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT, "count over capacity")
    `SKVT_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, w_accept, w_exec, "no execute after accept")
    `SKVT_ASSERT_NOW(a_iter_range, i_clk, i_rst_n, r_iter_valid, w_iter_next <= r_count, "walk past end")
    `SKVT_ASSERT_NOW(a_unique_match, i_clk, i_rst_n, w_exec, $onehot0(w_match), "key held twice")

endmodule

`default_nettype wire

### dv/sorted_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted key/value table: watches the request, reply and register channels,
// keeps its own copy of the table, predicts each reply and compares it field by field.
// Depends on skvt_pkg for the operation and status codes.

module sorted_table_checker #(
    parameter int CAPACITY = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    // func[2:0], key[34:3], value[66:35], zero[71:67]
    input  wire  [skvt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    // status[1:0], found[2], key_out[34:3], data_out[66:35], entries[71:67]
    input  wire  [skvt_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_results,
    output int                               o_pending
);

    // One reply, packed in the order of the reply stream (lowest field last here)
    typedef struct packed {
        logic [skvt_pkg::ENTRIES_W-1:0] entries;
        logic [skvt_pkg::FIELD_W-1:0]   data_out;
        logic [skvt_pkg::FIELD_W-1:0]   key_out;
        logic                           found;
        logic [skvt_pkg::STATUS_W-1:0]  status;
    } t_table_reply;

    // Shadow table
    logic [skvt_pkg::FIELD_W-1:0] shadow_keys [CAPACITY];
    logic [skvt_pkg::FIELD_W-1:0] shadow_vals [CAPACITY];
    int                 shadow_count;
    int                 walk_pos;
    logic               walk_on;
    logic               order_signed;

    t_table_reply expected_replies [$];
    int           fail_count;
    int           result_count;

    // Apply one operation to the shadow table and return the reply it should produce
    function automatic t_table_reply predict_reply(logic [2:0] op,
                                                   logic [skvt_pkg::FIELD_W-1:0] key,
                                                   logic [skvt_pkg::FIELD_W-1:0] value);
        t_table_reply r;
        int           pos;
        r = '0;
        r.status = skvt_pkg::ST_MISSING;
        // linear lookup over the live entries
        pos = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_keys[i] == key) pos = i;
        end
        case (skvt_pkg::t_func'(op))
            skvt_pkg::FN_PUT: begin
                walk_on = 1'b0;
                if (pos >= 0) begin
                    shadow_vals[pos] = value;
                    r.status = skvt_pkg::ST_OK;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = skvt_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_count &&
                           (order_signed ? ($signed(shadow_keys[pos]) < $signed(key))
                                         : (shadow_keys[pos] < key)))
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[pos] = key;
                    shadow_vals[pos] = value;
                    shadow_count++;
                    r.status = skvt_pkg::ST_OK;
                end
            end
            skvt_pkg::FN_GET: begin
                if (pos >= 0) begin
                    r.status   = skvt_pkg::ST_OK;
                    r.found    = 1'b1;
                    r.key_out  = shadow_keys[pos];
                    r.data_out = shadow_vals[pos];
                end
            end
            skvt_pkg::FN_REMOVE: begin
                walk_on = 1'b0;
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_count--;
                    r.status = skvt_pkg::ST_OK;
                end
            end
            skvt_pkg::FN_FIRST: begin
                if (shadow_count == 0) begin
                    walk_on = 1'b0;
                end else begin
                    walk_pos   = 0;
                    walk_on    = 1'b1;
                    r.status   = skvt_pkg::ST_OK;
                    r.found    = 1'b1;
                    r.key_out  = shadow_keys[0];
                    r.data_out = shadow_vals[0];
                end
            end
            skvt_pkg::FN_NEXT: begin
                if (!walk_on || walk_pos + 1 >= shadow_count) begin
                    walk_on = 1'b0;
                end else begin
                    walk_pos++;
                    r.status   = skvt_pkg::ST_OK;
                    r.found    = 1'b1;
                    r.key_out  = shadow_keys[walk_pos];
                    r.data_out = shadow_vals[walk_pos];
                end
            end
            skvt_pkg::FN_CLEAR: begin
                shadow_count = 0;
                walk_on      = 1'b0;
                walk_pos     = 0;
                r.status     = skvt_pkg::ST_OK;
            end
            default: ;  // unused codes do nothing
        endcase
        r.entries = shadow_count[skvt_pkg::ENTRIES_W-1:0];
        return r;
    endfunction

    // Track both channels; replies are retired before new requests in the same cycle
    always @(posedge i_clk) begin
        t_table_reply got;
        t_table_reply want;
        if (!i_rst_n) begin
            shadow_count = 0;
            walk_pos     = 0;
            walk_on      = 1'b0;
            order_signed = 1'b0;
            fail_count   = 0;
            result_count = 0;
            expected_replies.delete();
        end else begin
            if (i_cfg_we) order_signed = i_cfg_wdata;

            // reply transaction
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                result_count++;
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected reply st=%0d f=%0d k=%h d=%h n=%0d",
                                 $realtime, got.status, got.found, got.key_out,
                                 got.data_out, got.entries);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.key_out !== want.key_out || got.data_out !== want.data_out ||
                        got.entries !== want.entries) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: reply mismatch exp st=%0d f=%0d k=%h d=%h n=%0d,",
                                      " got st=%0d f=%0d k=%h d=%h n=%0d"},
                                     $realtime, want.status, want.found, want.key_out,
                                     want.data_out, want.entries, got.status, got.found,
                                     got.key_out, got.data_out, got.entries);
                    end
                end
            end

            // request transaction
            if (i_s_tvalid && i_s_tready)
                expected_replies.push_back(predict_reply(
                    i_s_tdata[skvt_pkg::FUNC_W-1:0],
                    i_s_tdata[skvt_pkg::FUNC_W +: skvt_pkg::FIELD_W],
                    i_s_tdata[skvt_pkg::FUNC_W+skvt_pkg::FIELD_W +: skvt_pkg::FIELD_W]));
        end
        o_fail_count <= fail_count;
        o_results    <= result_count;
        o_pending    <= expected_replies.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted key/value table: clock, reset, request stimulus, reply stalls.
// Depends on skvt_pkg, sorted_key_value_table_top and sorted_table_checker.

module tb;

    localparam int CAPACITY  = 16;
    localparam int POOL_SIZE = 24;
    localparam int PER_PHASE = 110;

    // Codes past the defined operations
    localparam logic [skvt_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [skvt_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [skvt_pkg::IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire [skvt_pkg::OUT_TDATA_W-1:0]  m_data;
    int                     fail_count;
    int                     results_seen;
    int                     pending;

    int                     requests_sent = 0;
    logic                   calm = 1'b0;   // no idling on either side
    int                     stall_left = 0;
    logic [skvt_pkg::FIELD_W-1:0]     key_pool [POOL_SIZE];

    sorted_key_value_table_top #(
        .CAPACITY   (CAPACITY),
        .KEY_WIDTH  (skvt_pkg::FIELD_W),
        .DATA_WIDTH (skvt_pkg::FIELD_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    sorted_table_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_results    (results_seen),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Reply side: ready drops in random bursts unless the run is in its calm tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Send one request, with an optional gap before it
    task automatic send_op(input logic [skvt_pkg::FUNC_W-1:0] op,
                           input logic [skvt_pkg::FIELD_W-1:0] key,
                           input logic [skvt_pkg::FIELD_W-1:0] value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {5'd0, value, key, op};
        do @(posedge i_clk); while (!s_ready);
        requests_sent++;
    endtask

    // Hold off until every reply is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_seen != requests_sent) @(posedge i_clk);
    endtask

    // Register write with the table idle
    task automatic write_order(input logic signed_keys);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= signed_keys;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Keys mostly from a small pool so puts, gets and removes hit each other
    function automatic logic [skvt_pkg::FIELD_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic refresh_pool();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    endtask

    // Clear, fill (sometimes past capacity), then walk in key order
    task automatic fill_and_walk();
        int base;
        int fill;
        base = $urandom_range(0, POOL_SIZE - 1);
        fill = $urandom_range(10, 20);
        send_op(skvt_pkg::FN_CLEAR, $urandom, $urandom);
        for (int i = 0; i < fill; i++)
            send_op(skvt_pkg::FN_PUT, key_pool[(base + i) % POOL_SIZE], $urandom);
        send_op(skvt_pkg::FN_FIRST, $urandom, $urandom);
        repeat ($urandom_range(4, 18)) begin
            if ($urandom_range(0, 7) == 0) send_op(skvt_pkg::FN_GET, pick_key(), $urandom);
            else send_op(skvt_pkg::FN_NEXT, $urandom, $urandom);
        end
    endtask

    // Weighted mix of every operation
    task automatic random_mix(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      send_op(skvt_pkg::FN_PUT, pick_key(), $urandom);
            else if (pick < 55) send_op(skvt_pkg::FN_GET, pick_key(), $urandom);
            else if (pick < 68) send_op(skvt_pkg::FN_REMOVE, pick_key(), $urandom);
            else if (pick < 76) send_op(skvt_pkg::FN_FIRST, $urandom, $urandom);
            else if (pick < 97) send_op(skvt_pkg::FN_NEXT, $urandom, $urandom);
            else                send_op(skvt_pkg::FN_CLEAR, $urandom, $urandom);
        end
    endtask

    // Main sequence
    initial begin
        int           phase_end;
        logic [1:0]   order_list [4];
        order_list = '{1, 0, 1, 0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table cases, extreme keys, replace, walk past end, spare codes
        send_op(skvt_pkg::FN_FIRST, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_NEXT, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_GET, 32'h5, 32'h0);
        send_op(skvt_pkg::FN_REMOVE, 32'h5, 32'h0);
        send_op(skvt_pkg::FN_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(skvt_pkg::FN_PUT, 32'h0000_0000, 32'h0000_0000);
        send_op(skvt_pkg::FN_PUT, 32'h8000_0000, 32'hA5A5_A5A5);
        send_op(skvt_pkg::FN_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        send_op(skvt_pkg::FN_PUT, 32'h8000_0000, 32'h1234_5678);
        send_op(skvt_pkg::FN_FIRST, 32'h0, 32'h0);
        repeat (4) send_op(skvt_pkg::FN_NEXT, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_FIRST, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_REMOVE, 32'h7FFF_FFFF, 32'h0);
        send_op(skvt_pkg::FN_NEXT, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_GET, 32'hFFFF_FFFF, 32'h0);
        send_op(FN_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FN_SPARE_HI, 32'h0, 32'h0);

        // Key order switched while entries are held: table no longer sorted that way
        write_order(1'b1);
        send_op(skvt_pkg::FN_PUT, 32'h0000_0005, 32'h0BAD_0005);
        send_op(skvt_pkg::FN_PUT, 32'hC000_0000, 32'h0BAD_C000);
        send_op(skvt_pkg::FN_REMOVE, 32'h8000_0000, 32'h0);
        send_op(skvt_pkg::FN_PUT, 32'h4000_0000, 32'h0BAD_4000);
        send_op(skvt_pkg::FN_FIRST, 32'h0, 32'h0);
        repeat (5) send_op(skvt_pkg::FN_NEXT, 32'h0, 32'h0);
        write_order(1'b0);

        send_op(skvt_pkg::FN_CLEAR, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_GET, 32'h0, 32'h0);
        send_op(skvt_pkg::FN_FIRST, 32'h0, 32'h0);

        // Random phases, alternating key order; the last one runs without idling
        for (int p = 0; p < 4; p++) begin
            write_order(order_list[p][0]);
            if (p == 3) calm = 1'b1;
            refresh_pool();
            phase_end = requests_sent + PER_PHASE;
            fill_and_walk();
            while (requests_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0) fill_and_walk();
                else random_mix($urandom_range(10, 30));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_cell.sv
hw/rtl/sorted_key_value_table_top.sv
dv/sorted_table_checker.sv
dv/tb.sv
